// ===== rtl/core/crc32_response_checker_unit_macros.svh =====
// Assertion macros shared by the response checker RTL.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef CRC32_RESPONSE_CHECKER_UNIT_MACROS_SVH
`define CRC32_RESPONSE_CHECKER_UNIT_MACROS_SVH

// Same-cycle implication, held off during reset
`define CRC32RC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("crc32rc same-cycle check failed");

// Next-cycle implication, held off during reset
`define CRC32RC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("crc32rc next-cycle check failed");

`endif

// ===== rtl/core/crc32rc_pkg.sv =====
// Package for the CRC-32 response checker: constants, item type, byte fold.
// No dependencies.
package crc32rc_pkg;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    // Message byte kinds
    localparam logic FUNC_PAYLOAD = 1'b0;
    localparam logic FUNC_STATUS  = 1'b1;

    typedef struct packed {
        logic        func;
        logic [7:0]  data_byte;
        logic [31:0] expected_crc;
    } t_item;

    // Reflected CRC-32 update over one byte, LSB first
    function automatic logic [31:0] fold_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/crc32_response_checker_unit.sv =====
// Top level of the CRC-32 response checker.
// Depends on crc32rc_pkg, crc32rc_in_stage, crc32rc_fold, crc32rc_out_reg, macro header.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  in      | to block  | i_valid / o_ready  | i_func, i_data_byte, i_expected_crc
//  out     | from block| o_valid / i_ready  | o_computed_crc, o_crc_ok
//
// One item per cycle unless a stalled output holds a status item. An item waits in the
// input register; the 8-bit unrolled CRC fold sits between it and the running CRC and
// the result register, which takes a status item's result as it leaves the input register.
// Reset (synchronous, i_rst_n low) empties both registers and loads the CRC with all ones.
// A stalled output holds back status items and those queued behind them; others flow on.
`include "crc32_response_checker_unit_macros.svh"

module crc32_response_checker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic [7:0]  i_data_byte,
    input  logic [31:0] i_expected_crc,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_computed_crc,
    output logic        o_crc_ok
);
    import crc32rc_pkg::*;

    t_item       in_item;
    t_item       a_item;
    logic        a_valid;
    logic        a_moves;
    logic        out_free;
    logic        out_load;
    logic [31:0] fold_crc;
    logic        fold_ok;

    assign in_item = '{func: i_func, data_byte: i_data_byte, expected_crc: i_expected_crc};

    // Held item leaves when it is payload or when the result slot is free
    assign a_moves  = a_valid && ((a_item.func == FUNC_PAYLOAD) || out_free);
    assign out_load = a_moves && (a_item.func == FUNC_STATUS);

    crc32rc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (in_item),
        .i_take  (a_moves),
        .o_ready (o_ready),
        .o_valid (a_valid),
        .o_item  (a_item)
    );

    crc32rc_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (a_moves),
        .i_item  (a_item),
        .o_crc   (fold_crc),
        .o_ok    (fold_ok)
    );

    crc32rc_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_crc   (fold_crc),
        .i_ok    (fold_ok),
        .i_ready (i_ready),
        .o_free  (out_free),
        .o_valid (o_valid),
        .o_crc   (o_computed_crc),
        .o_ok    (o_crc_ok)
    );

    `CRC32RC_ASSERT_NEXT(a_status_gives_result, out_load, o_valid)
    `CRC32RC_ASSERT_NOW(a_blocked_status_stalls,
                        a_valid && (a_item.func == FUNC_STATUS) && o_valid && !i_ready,
                        !o_ready)
    `CRC32RC_ASSERT_NEXT(a_payload_no_result, a_moves && (a_item.func == FUNC_PAYLOAD)
                         && !(o_valid && !i_ready), !o_valid)
endmodule

// ===== rtl/core/crc32rc_in_stage.sv =====
// Input register of the response checker: holds one item and its valid bit.
// Depends on crc32rc_pkg.
module crc32rc_in_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  crc32rc_pkg::t_item   i_item,
    input  logic                 i_take,
    output logic                 o_ready,
    output logic                 o_valid,
    output crc32rc_pkg::t_item   o_item
);
    import crc32rc_pkg::*;

    logic  r_valid;
    t_item r_item;

    // Free when empty or when the held item leaves this cycle
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload register, no reset
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

// ===== rtl/core/crc32rc_fold.sv =====
// Running CRC register and one-byte fold with the match compare.
// Depends on crc32rc_pkg and the assertion macro header.
`include "crc32_response_checker_unit_macros.svh"

module crc32rc_fold (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  crc32rc_pkg::t_item   i_item,
    output logic [31:0]          o_crc,
    output logic                 o_ok
);
    import crc32rc_pkg::*;

    logic [31:0] r_crc;
    logic [31:0] n_crc;
    logic [31:0] folded;

    assign folded = fold_byte(r_crc, i_item.data_byte);
    assign o_crc  = folded;
    assign o_ok   = (folded == i_item.expected_crc);

    // Status byte restarts the CRC for the next message
    always_comb begin
        n_crc = r_crc;
        if (i_fire) begin
            n_crc = (i_item.func == FUNC_STATUS) ? CRC_INIT : folded;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else begin
            r_crc <= n_crc;
        end
    end

    `CRC32RC_ASSERT_NEXT(a_restart, i_fire && (i_item.func == FUNC_STATUS), r_crc == CRC_INIT)
    `CRC32RC_ASSERT_NEXT(a_hold, !i_fire, r_crc == $past(r_crc))
    `CRC32RC_ASSERT_NEXT(a_payload_fold, i_fire && (i_item.func == FUNC_PAYLOAD),
                         r_crc == $past(folded))
endmodule

// ===== rtl/core/crc32rc_out_reg.sv =====
// Result register: holds one finished CRC and match flag until taken.
// Depends on nothing outside this file.
module crc32rc_out_reg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  logic [31:0] i_crc,
    input  logic        i_ok,
    input  logic        i_ready,
    output logic        o_free,
    output logic        o_valid,
    output logic [31:0] o_crc,
    output logic        o_ok
);
    logic        r_valid;
    logic [31:0] r_crc;
    logic        r_ok;

    // Slot can take a new item when empty or being drained
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_crc <= i_crc;
            r_ok  <= i_ok;
        end
    end

    assign o_valid = r_valid;
    assign o_crc   = r_crc;
    assign o_ok    = r_ok;
endmodule

// ===== bench/crc32rc_bench_pkg.sv =====
// Shared bench helpers for the CRC-32 response checker: the byte-wise CRC update.
// Depends on crc32rc_pkg for the CRC constants.
package crc32rc_bench_pkg;

    import crc32rc_pkg::*;

    // Reflected CRC-32 update over one byte, one bit at a time, LSB first
    function automatic logic [31:0] crc_after_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] r;
        logic        fb;
        r = crc;
        for (int i = 0; i < 8; i++) begin
            fb = r[0] ^ b[i];
            r  = (r >> 1) ^ (fb ? CRC_POLY : 32'd0);
        end
        return r;
    endfunction

endpackage

// ===== bench/crc32rc_response_monitor.sv =====
// Monitor for the CRC-32 response checker: predicts the CRC verdict of every
// closed message and compares it with the block's results.
// Depends on crc32rc_pkg and crc32rc_bench_pkg.
module crc32rc_response_monitor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic        i_func,
    input  logic [7:0]  i_data_byte,
    input  logic [31:0] i_expected_crc,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [31:0] o_computed_crc,
    input  logic        o_crc_ok,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_item_count,
    output int          o_result_count,
    output int          o_match_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import crc32rc_pkg::*;
    import crc32rc_bench_pkg::*;

    typedef struct packed {
        logic [31:0] crc;
        logic        ok;
    } t_crc_verdict;

    t_crc_verdict verdict_q[$];
    logic [31:0]  msg_crc;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
        o_fail_count++;
    endtask

    // Compare one accepted result with the oldest predicted verdict
    task automatic check_result();
        t_crc_verdict want;
        if (verdict_q.size() == 0) begin
            report_mismatch("result with no closed message pending", o_computed_crc, 32'd0);
        end else begin
            want = verdict_q.pop_front();
            if (o_computed_crc !== want.crc)
                report_mismatch("computed_crc", o_computed_crc, want.crc);
            if (o_crc_ok !== want.ok)
                report_mismatch("crc_ok", {31'd0, o_crc_ok}, {31'd0, want.ok});
        end
        o_result_count++;
        if (o_crc_ok === 1'b1)
            o_match_count++;
    endtask

    // Fold one accepted item; a status item closes the message
    task automatic predict_item();
        logic [31:0] c;
        c = crc_after_byte(msg_crc, i_data_byte);
        o_item_count++;
        if (i_func == FUNC_STATUS) begin
            verdict_q.push_back('{crc: c, ok: (c == i_expected_crc)});
            msg_crc = CRC_INIT;
        end else begin
            msg_crc = c;
        end
    endtask

    // Sample both channels at each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            msg_crc        = CRC_INIT;
            o_fail_count   = 0;
            o_item_count   = 0;
            o_result_count = 0;
            o_match_count  = 0;
            verdict_q.delete();
        end else begin
            if (o_valid && i_ready)
                check_result();
            if (i_valid && o_ready)
                predict_item();
        end
        o_pending <= verdict_q.size();
    end

endmodule

// ===== bench/testbench.sv =====
// Top of the CRC-32 response checker bench: clock, reset, message stimulus, verdict.
// Depends on crc32rc_pkg, crc32rc_bench_pkg, crc32rc_response_monitor and the block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import crc32rc_pkg::*;
    import crc32rc_bench_pkg::*;

    typedef enum int {EXP_MATCH, EXP_FLIP, EXP_RANDOM, EXP_ZERO, EXP_ONES} t_exp_kind;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_func;
    logic [7:0]  i_data_byte;
    logic [31:0] i_expected_crc;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_computed_crc;
    logic        o_crc_ok;

    int fail_count, pending, item_count, result_count, match_count;
    int gap_pct   = 0;
    int stall_pct = 0;

    always #5 i_clk = ~i_clk;

    crc32_response_checker_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_data_byte    (i_data_byte),
        .i_expected_crc (i_expected_crc),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_computed_crc (o_computed_crc),
        .o_crc_ok       (o_crc_ok)
    );

    crc32rc_response_monitor u_monitor (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_data_byte    (i_data_byte),
        .i_expected_crc (i_expected_crc),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_computed_crc (o_computed_crc),
        .o_crc_ok       (o_crc_ok),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_item_count   (item_count),
        .o_result_count (result_count),
        .o_match_count  (match_count)
    );

    // Receiver: random stalls at the current phase's rate
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Drive one item after a random idle gap, return once it is accepted
    task automatic send_item(input logic f, input logic [7:0] b, input logic [31:0] e);
        int gap = 0;
        while ($urandom_range(0, 99) < gap_pct)
            gap++;
        if (gap > 0) begin
            i_valid        <= 1'b0;
            i_func         <= 1'($urandom);
            i_data_byte    <= 8'($urandom);
            i_expected_crc <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_func         <= f;
        i_data_byte    <= b;
        i_expected_crc <= e;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Send a message; the last byte is the status byte
    task automatic send_message(input logic [7:0] bytes[$], input t_exp_kind kind);
        logic [31:0] crc;
        logic [31:0] e;
        crc = CRC_INIT;
        foreach (bytes[i]) begin
            crc = crc_after_byte(crc, bytes[i]);
            if (i < bytes.size() - 1)
                send_item(FUNC_PAYLOAD, bytes[i], $urandom);
        end
        case (kind)
            EXP_MATCH: e = crc;
            EXP_FLIP:  e = crc ^ (32'd1 << $urandom_range(0, 31));
            EXP_ZERO:  e = 32'd0;
            EXP_ONES:  e = 32'hFFFF_FFFF;
            default:   e = $urandom;
        endcase
        send_item(FUNC_STATUS, bytes[bytes.size() - 1], e);
    endtask

    // Random messages until about n items have gone out
    task automatic run_phase(input int gap, input int stall, input int n);
        logic [7:0] msg[$];
        int         len;
        int         r;
        int         sent;
        gap_pct   = gap;
        stall_pct = stall;
        sent      = 0;
        while (sent < n) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 48) : $urandom_range(0, 8);
            msg.delete();
            for (int i = 0; i <= len; i++)
                msg.push_back(8'($urandom));
            r = $urandom_range(0, 7);
            send_message(msg, (r < 4) ? EXP_MATCH : (r < 6) ? EXP_FLIP : EXP_RANDOM);
            sent += len + 1;
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_func         <= FUNC_PAYLOAD;
        i_data_byte    <= 8'd0;
        i_expected_crc <= 32'd0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: lone status bytes, byte extremes, the check string, bad CRCs
        send_message('{8'h00}, EXP_MATCH);
        send_message('{8'hFF}, EXP_ONES);
        send_message('{8'h00, 8'hFF, 8'h5A}, EXP_MATCH);
        send_message('{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
                       8'h00}, EXP_MATCH);
        send_message('{8'hA5}, EXP_ZERO);
        send_message('{8'h3C, 8'hC3}, EXP_FLIP);

        // Random messages under each idling pattern
        run_phase(0, 0, 410);
        run_phase(63, 0, 410);
        run_phase(0, 63, 410);
        run_phase(15, 15, 410);
        i_valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (pending != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d bytes; %0d messages closed, %0d with a matching CRC.",
                 item_count, result_count, match_count);
        $display("Idling phases: none, sender gaps, receiver stalls, both.");
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", pending);
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/crc32rc_pkg.sv
rtl/core/crc32rc_in_stage.sv
rtl/core/crc32rc_fold.sv
rtl/core/crc32rc_out_reg.sv
rtl/core/crc32_response_checker_unit.sv
bench/crc32rc_bench_pkg.sv
bench/crc32rc_response_monitor.sv
bench/testbench.sv
